// ===== sv/ffa_pkg.sv =====
package ffa_pkg;

   localparam int COUNT_WIDTH_DEF    = 32;
   localparam int BYTE_WIDTH_DEF     = 48;
   localparam int MEAN_FRAC_BITS_DEF = 16;
   localparam int M2_FRAC_BITS       = 8;

   localparam int MEAN_W    = 64;
   localparam int M2_W      = 64;
   localparam int SAMPLE_W  = 48;
   localparam int NUM_STATS = 10;
   localparam int NUM_SLOTS = 8;
   localparam int NUM_FLAGS = 5;

   // request tdata layout, lowest bit first
   localparam int REQ_DATA_W  = 184;
   localparam int RSP_DATA_W  = 8;
   localparam int DIR_LSB     = 0;
   localparam int WIRE_LSB    = 1;
   localparam int HDR_LSB     = 17;
   localparam int PAY_LSB     = 33;
   localparam int FGV_LSB     = 49;
   localparam int FGAP_LSB    = 50;
   localparam int DGV_LSB     = 98;
   localparam int DGAP_LSB    = 99;
   localparam int TCP_LSB     = 147;
   localparam int FLAGS_LSB   = 148;
   localparam int WIN_LSB     = 153;
   localparam int TTL_LSB     = 169;

   // statistic indexes
   localparam logic [3:0] STAT_WIRE     = 4'd0;
   localparam logic [3:0] STAT_FWD_LEN  = 4'd1;
   localparam logic [3:0] STAT_FLOW_GAP = 4'd3;
   localparam logic [3:0] STAT_FWD_GAP  = 4'd4;
   localparam logic [3:0] STAT_WINDOW   = 4'd6;
   localparam logic [3:0] STAT_TTL      = 4'd7;
   localparam logic [3:0] STAT_PAYLOAD  = 4'd8;
   localparam logic [3:0] STAT_HEADER   = 4'd9;

   // slot in which the TCP window statistic is taken
   localparam logic [3:0] SLOT_WINDOW = 4'd4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_PICK   = 9'b000000010,
      ST_LOAD   = 9'b000000100,
      ST_PREP   = 9'b000001000,
      ST_DIV    = 9'b000010000,
      ST_MUL    = 9'b000100000,
      ST_FIN    = 9'b001000000,
      ST_COMMIT = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

endpackage

// ===== sv/ffa_divider.sv =====
module ffa_divider #(
   parameter int DW = 64,
   parameter int NW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [NW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;
   logic [NW:0]   trial;
   logic [NW:0]   diff;
   logic          ge;

   // restoring division, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = ~diff[NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[NW-1:0] : trial[NW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/ffa_mult.sv =====
module ffa_mult (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic         done,
   output logic [127:0] product
);

   logic [1:0]   step_ff;
   logic         run_ff;
   logic         pv_ff;
   logic         plast_ff;
   logic [1:0]   sh_ff;
   logic [63:0]  pr_ff;
   logic [127:0] acc_ff;
   logic         done_ff;
   logic [31:0]  aw;
   logic [31:0]  bw;

   assign aw = step_ff[1] ? op_a[63:32] : op_a[31:0];
   assign bw = step_ff[0] ? op_b[63:32] : op_b[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         pv_ff    <= 1'b0;
         plast_ff <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         done_ff  <= pv_ff & plast_ff;
         pv_ff    <= run_ff;
         plast_ff <= run_ff && (step_ff == 2'd3);
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) run_ff <= 1'b0;
         end
      end
   end

   // one 32x32 partial product a cycle, accumulated in the cycle after it is registered
   always_ff @(posedge clock) begin
      if (start) acc_ff <= '0;
      else if (pv_ff) acc_ff <= acc_ff + ({64'b0, pr_ff} << (32 * sh_ff));
      if (run_ff) begin
         pr_ff <= aw * bw;
         sh_ff <= {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== sv/flow_feature_accumulator.sv =====
// Per-flow packet feature accumulator. Each request carries one packet's metadata and gives
// one response with a status (ok, counter overflow, out-of-range statistic); on any failure
// no state changes. A request goes straight to its response when the byte counter overflows,
// and it may also wait for the previous response to leave. Up to eight running statistics
// are updated one after another through a shared divider and multiplier. A full update runs
// the divider, which produces one quotient bit a cycle, and then the multiplier; a first
// sample skips both, and a skipped statistic only advances the slot. A passing update ends
// with a commit sweep over all eight staged slots. A new request is taken only in idle; a
// finished response may still wait in the output register meanwhile.
module flow_feature_accumulator #(
   parameter int COUNT_WIDTH    = ffa_pkg::COUNT_WIDTH_DEF,
   parameter int BYTE_WIDTH     = ffa_pkg::BYTE_WIDTH_DEF,
   parameter int MEAN_FRAC_BITS = ffa_pkg::MEAN_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // dir, wire_len, hdr_len, pay_len, fgap_valid, fgap_ns, dgap_valid, dgap_ns,
   // is_tcp, tcp_flags, win_size, ip_ttl, zero fill
   input  logic [ffa_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status, zero fill
   output logic [ffa_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int NW    = COUNT_WIDTH + 1;
   localparam int SH    = 63 - MEAN_FRAC_BITS;
   localparam int EXT_W = 128 + ffa_pkg::M2_FRAC_BITS;
   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

   ffa_pkg::state_type  state_ff, state_in;
   ffa_pkg::status_type status_ff, status_in;
   logic [3:0]                  slot_ff, slot_in;
   logic [ffa_pkg::REQ_DATA_W-1:0] in_ff;

   logic [COUNT_WIDTH-1:0] count_ff [ffa_pkg::NUM_STATS];
   logic [47:0]            min_ff   [ffa_pkg::NUM_STATS];
   logic [47:0]            max_ff   [ffa_pkg::NUM_STATS];
   logic [63:0]            mean_ff  [ffa_pkg::NUM_STATS];
   logic [63:0]            m2_ff    [ffa_pkg::NUM_STATS];

   logic [BYTE_WIDTH-1:0]  wb_ff [3];
   logic [BYTE_WIDTH-1:0]  pb_ff [3];
   logic [COUNT_WIDTH-1:0] pp_ff [3];
   logic [COUNT_WIDTH-1:0] dc_ff;
   logic                   ld_valid_ff, ld_dir_ff;
   logic [COUNT_WIDTH-1:0] fc_ff [ffa_pkg::NUM_FLAGS];
   logic [1:0]             fw_valid_ff;
   logic [15:0]            fw_ff [2];

   // working copy of the statistic in hand
   logic [3:0]             k_ff;
   logic [63:0]            x_ff;
   logic [COUNT_WIDTH-1:0] cnt_w_ff;
   logic [47:0]            min_w_ff, max_w_ff;
   logic [63:0]            mean_w_ff, m2_w_ff, mag_ff;
   logic                   up_ff;

   // staged results, one entry per slot
   logic [ffa_pkg::NUM_SLOTS-1:0] bv_ff;
   logic [3:0]             bk_ff    [ffa_pkg::NUM_SLOTS];
   logic [COUNT_WIDTH-1:0] bcnt_ff  [ffa_pkg::NUM_SLOTS];
   logic [47:0]            bmin_ff  [ffa_pkg::NUM_SLOTS];
   logic [47:0]            bmax_ff  [ffa_pkg::NUM_SLOTS];
   logic [63:0]            bmean_ff [ffa_pkg::NUM_SLOTS];
   logic [63:0]            bm2_ff   [ffa_pkg::NUM_SLOTS];

   logic                   rsp_valid_ff;
   ffa_pkg::status_type    rsp_status_ff;

   logic        f_dir, f_fgv, f_dgv, f_tcp;
   logic [15:0] f_wire, f_hdr, f_pay, f_win;
   logic [47:0] f_fgap, f_dgap;
   logic [4:0]  f_flags;
   logic [7:0]  f_ttl;
   logic [1:0]  di;

   logic [3:0]  k_sel;
   logic        slot_en;
   logic [63:0] x_sel;
   logic        wire_fail, dc_fail, flag_fail, pay_fail;
   logic [BYTE_WIDTH:0] ws0, ws1, ps0, ps1;

   logic [63:0] xs, mag_c, e_val, q_val, new_mean;
   logic        up_c, range_bad, cnt_full, div_done, mul_done, div_start, mul_start;
   logic [127:0] prod;
   logic [EXT_W-1:0] ext;
   logic [64:0] m2_sum;
   logic        fin_bad, buf_first, buf_full, done_fire;
   logic [NW-1:0] n_val;
   logic [2:0]  cj;
   ffa_pkg::status_type slot_status;

   assign f_dir   = in_ff[ffa_pkg::DIR_LSB];
   assign f_wire  = in_ff[ffa_pkg::WIRE_LSB +: 16];
   assign f_hdr   = in_ff[ffa_pkg::HDR_LSB +: 16];
   assign f_pay   = in_ff[ffa_pkg::PAY_LSB +: 16];
   assign f_fgv   = in_ff[ffa_pkg::FGV_LSB];
   assign f_fgap  = in_ff[ffa_pkg::FGAP_LSB +: 48];
   assign f_dgv   = in_ff[ffa_pkg::DGV_LSB];
   assign f_dgap  = in_ff[ffa_pkg::DGAP_LSB +: 48];
   assign f_tcp   = in_ff[ffa_pkg::TCP_LSB];
   assign f_flags = in_ff[ffa_pkg::FLAGS_LSB +: 5];
   assign f_win   = in_ff[ffa_pkg::WIN_LSB +: 16];
   assign f_ttl   = in_ff[ffa_pkg::TTL_LSB +: 8];
   // forward counters sit at index 1, reverse at index 2
   assign di      = {f_dir, ~f_dir};

   always_comb begin
      k_sel   = ffa_pkg::STAT_WIRE;
      slot_en = 1'b1;
      x_sel   = {48'b0, f_wire};
      case (slot_ff[2:0])
         3'd0: k_sel = ffa_pkg::STAT_WIRE;
         3'd1: k_sel = ffa_pkg::STAT_FWD_LEN + {3'b0, f_dir};
         3'd2: begin
            k_sel   = ffa_pkg::STAT_FLOW_GAP;
            slot_en = f_fgv;
            x_sel   = {{16{f_fgap[47]}}, f_fgap};
         end
         3'd3: begin
            k_sel   = ffa_pkg::STAT_FWD_GAP + {3'b0, f_dir};
            slot_en = f_dgv;
            x_sel   = {{16{f_dgap[47]}}, f_dgap};
         end
         3'd4: begin
            k_sel   = ffa_pkg::STAT_WINDOW;
            slot_en = f_tcp;
            x_sel   = {48'b0, f_win};
         end
         3'd5: begin
            k_sel = ffa_pkg::STAT_TTL;
            x_sel = {56'b0, f_ttl};
         end
         3'd6: begin
            k_sel = ffa_pkg::STAT_PAYLOAD;
            x_sel = {48'b0, f_pay};
         end
         default: begin
            k_sel = ffa_pkg::STAT_HEADER;
            x_sel = {48'b0, f_hdr};
         end
      endcase
   end

   // counter overflow checks against the committed state
   assign ws0 = {1'b0, wb_ff[0]} + (BYTE_WIDTH + 1)'(f_wire);
   assign ws1 = {1'b0, wb_ff[di]} + (BYTE_WIDTH + 1)'(f_wire);
   assign ps0 = {1'b0, pb_ff[0]} + (BYTE_WIDTH + 1)'(f_pay);
   assign ps1 = {1'b0, pb_ff[di]} + (BYTE_WIDTH + 1)'(f_pay);
   assign wire_fail = ws0[BYTE_WIDTH] | ws1[BYTE_WIDTH];
   assign dc_fail   = ld_valid_ff && (ld_dir_ff != f_dir) && (dc_ff == CMAX);
   always_comb begin
      flag_fail = 1'b0;
      for (int b = 0; b < ffa_pkg::NUM_FLAGS; b++)
         if (f_flags[b] && fc_ff[b] == CMAX) flag_fail = 1'b1;
   end
   assign pay_fail = ps0[BYTE_WIDTH] | ps1[BYTE_WIDTH]
                   | ((f_pay != 16'd0) && (pp_ff[0] == CMAX || pp_ff[di] == CMAX));

   // shared statistic datapath
   assign xs        = x_ff << MEAN_FRAC_BITS;
   assign range_bad = !((x_ff[63:SH] == '0) || (x_ff[63:SH] == '1));
   assign cnt_full  = (cnt_w_ff == CMAX);
   assign up_c      = $signed(xs) >= $signed(mean_w_ff);
   assign mag_c     = up_c ? xs - mean_w_ff : mean_w_ff - xs;
   assign n_val     = {1'b0, cnt_w_ff} + NW'(1);
   assign e_val     = mag_ff - q_val;
   assign ext       = {prod, {ffa_pkg::M2_FRAC_BITS{1'b0}}} >> (2 * MEAN_FRAC_BITS);
   assign m2_sum    = {1'b0, m2_w_ff} + {1'b0, ext[63:0]};
   assign fin_bad   = (ext[EXT_W-1:64] != '0) | m2_sum[64];
   assign new_mean  = up_ff ? mean_w_ff + q_val : mean_w_ff - q_val;
   assign slot_status = (slot_ff < 4'd2) ? ffa_pkg::STATUS_OVERFLOW : ffa_pkg::STATUS_RANGE;
   assign cj        = slot_ff[2:0];

   ffa_divider #(.DW(64), .NW(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_c),
      .divisor  (n_val),
      .done     (div_done),
      .quotient (q_val)
   );

   ffa_mult u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mag_ff),
      .op_b    (e_val),
      .done    (mul_done),
      .product (prod)
   );

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      status_in = status_ff;
      div_start = 1'b0;
      mul_start = 1'b0;
      buf_first = 1'b0;
      buf_full  = 1'b0;
      done_fire = 1'b0;
      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in  = ffa_pkg::ST_PICK;
               slot_in   = '0;
               status_in = ffa_pkg::STATUS_OK;
            end
         end
         ffa_pkg::ST_PICK: begin
            if (slot_ff == 4'd0 && wire_fail) begin
               status_in = ffa_pkg::STATUS_OVERFLOW;
               state_in  = ffa_pkg::ST_DONE;
            end else if (slot_ff == ffa_pkg::SLOT_WINDOW && (dc_fail || (f_tcp && flag_fail)))
            begin
               status_in = ffa_pkg::STATUS_OVERFLOW;
               state_in  = ffa_pkg::ST_DONE;
            end else if (slot_ff == 4'(ffa_pkg::NUM_SLOTS)) begin
               if (pay_fail) begin
                  status_in = ffa_pkg::STATUS_OVERFLOW;
                  state_in  = ffa_pkg::ST_DONE;
               end else begin
                  slot_in  = '0;
                  state_in = ffa_pkg::ST_COMMIT;
               end
            end else if (slot_en) begin
               state_in = ffa_pkg::ST_LOAD;
            end else begin
               slot_in = slot_ff + 4'd1;
            end
         end
         ffa_pkg::ST_LOAD: state_in = ffa_pkg::ST_PREP;
         ffa_pkg::ST_PREP: begin
            if (cnt_full || range_bad) begin
               status_in = slot_status;
               state_in  = ffa_pkg::ST_DONE;
            end else if (cnt_w_ff == '0) begin
               buf_first = 1'b1;
               slot_in   = slot_ff + 4'd1;
               state_in  = ffa_pkg::ST_PICK;
            end else begin
               div_start = 1'b1;
               state_in  = ffa_pkg::ST_DIV;
            end
         end
         ffa_pkg::ST_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = ffa_pkg::ST_MUL;
            end
         end
         ffa_pkg::ST_MUL: if (mul_done) state_in = ffa_pkg::ST_FIN;
         ffa_pkg::ST_FIN: begin
            if (fin_bad) begin
               status_in = slot_status;
               state_in  = ffa_pkg::ST_DONE;
            end else begin
               buf_full = 1'b1;
               slot_in  = slot_ff + 4'd1;
               state_in = ffa_pkg::ST_PICK;
            end
         end
         ffa_pkg::ST_COMMIT: begin
            slot_in = slot_ff + 4'd1;
            if (cj == 3'd7) state_in = ffa_pkg::ST_DONE;
         end
         ffa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               done_fire = 1'b1;
               state_in  = ffa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::ST_IDLE;
         slot_ff      <= '0;
         status_ff    <= ffa_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
         bv_ff        <= '0;
         ld_valid_ff  <= 1'b0;
         fw_valid_ff  <= '0;
         dc_ff        <= '0;
         for (int i = 0; i < ffa_pkg::NUM_STATS; i++) count_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            wb_ff[i] <= '0;
            pb_ff[i] <= '0;
            pp_ff[i] <= '0;
         end
         for (int i = 0; i < ffa_pkg::NUM_FLAGS; i++) fc_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         status_ff <= status_in;
         if (state_ff == ffa_pkg::ST_IDLE && req_tvalid) bv_ff <= '0;
         if (buf_first || buf_full) bv_ff[cj] <= 1'b1;
         if (state_ff == ffa_pkg::ST_COMMIT && bv_ff[cj]) count_ff[bk_ff[cj]] <= bcnt_ff[cj];
         rsp_valid_ff <= done_fire | (rsp_valid_ff & ~rsp_tready);
         // apply the counters only once the whole update has passed
         if (done_fire && status_ff == ffa_pkg::STATUS_OK) begin
            wb_ff[0]  <= ws0[BYTE_WIDTH-1:0];
            wb_ff[di] <= ws1[BYTE_WIDTH-1:0];
            pb_ff[0]  <= ps0[BYTE_WIDTH-1:0];
            pb_ff[di] <= ps1[BYTE_WIDTH-1:0];
            if (f_pay != 16'd0) begin
               pp_ff[0]  <= pp_ff[0] + COUNT_WIDTH'(1);
               pp_ff[di] <= pp_ff[di] + COUNT_WIDTH'(1);
            end
            if (ld_valid_ff && ld_dir_ff != f_dir) dc_ff <= dc_ff + COUNT_WIDTH'(1);
            ld_valid_ff <= 1'b1;
            if (f_tcp) begin
               for (int b = 0; b < ffa_pkg::NUM_FLAGS; b++)
                  if (f_flags[b]) fc_ff[b] <= fc_ff[b] + COUNT_WIDTH'(1);
               fw_valid_ff[f_dir] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ffa_pkg::ST_IDLE && req_tvalid) in_ff <= req_tdata;
      if (done_fire) begin
         rsp_status_ff <= status_ff;
         if (status_ff == ffa_pkg::STATUS_OK) begin
            ld_dir_ff <= f_dir;
            if (f_tcp && !fw_valid_ff[f_dir]) fw_ff[f_dir] <= f_win;
         end
      end
      if (state_ff == ffa_pkg::ST_LOAD) begin
         k_ff      <= k_sel;
         x_ff      <= x_sel;
         cnt_w_ff  <= count_ff[k_sel];
         min_w_ff  <= min_ff[k_sel];
         max_w_ff  <= max_ff[k_sel];
         mean_w_ff <= mean_ff[k_sel];
         m2_w_ff   <= m2_ff[k_sel];
      end
      if (div_start) begin
         mag_ff <= mag_c;
         up_ff  <= up_c;
      end
      if (buf_first) begin
         bk_ff[cj]    <= k_ff;
         bcnt_ff[cj]  <= COUNT_WIDTH'(1);
         bmin_ff[cj]  <= x_ff[47:0];
         bmax_ff[cj]  <= x_ff[47:0];
         bmean_ff[cj] <= xs;
         bm2_ff[cj]   <= '0;
      end
      if (buf_full) begin
         bk_ff[cj]    <= k_ff;
         bcnt_ff[cj]  <= n_val[COUNT_WIDTH-1:0];
         bmin_ff[cj]  <= ($signed(x_ff[47:0]) < $signed(min_w_ff)) ? x_ff[47:0] : min_w_ff;
         bmax_ff[cj]  <= ($signed(max_w_ff) < $signed(x_ff[47:0])) ? x_ff[47:0] : max_w_ff;
         bmean_ff[cj] <= new_mean;
         bm2_ff[cj]   <= m2_sum[63:0];
      end
      if (state_ff == ffa_pkg::ST_COMMIT && bv_ff[cj]) begin
         min_ff[bk_ff[cj]]  <= bmin_ff[cj];
         max_ff[bk_ff[cj]]  <= bmax_ff[cj];
         mean_ff[bk_ff[cj]] <= bmean_ff[cj];
         m2_ff[bk_ff[cj]]   <= bm2_ff[cj];
      end
   end

   assign req_tready = (state_ff == ffa_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff};

endmodule

// ===== sv/ffa_checker.sv =====
module ffa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ffa_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ffa_pkg::STATUS_OK
                      || rsp_tdata[1:0] == ffa_pkg::STATUS_OVERFLOW
                      || rsp_tdata[1:0] == ffa_pkg::STATUS_RANGE)
                     && rsp_tdata[7:2] == 6'd0)
      else $error("bad status code");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind flow_feature_accumulator ffa_checker u_ffa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
